[rtl/core/uart_reg_pkg.sv]
// ----------------------------------------------------------------------------
// uart_reg_pkg
// Types and constants shared by the UART register block and its interfaces.
// ----------------------------------------------------------------------------
package uart_reg_pkg;

  // Kind of item on the request channel
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_RX    = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_t;

  // Word register map
  typedef enum logic [2:0] {
    REG_DATA   = 3'd0,
    REG_ENABLE = 3'd1,
    REG_IDENT  = 3'd2,
    REG_LCR    = 3'd3,
    REG_MCR    = 3'd4,
    REG_LSR    = 3'd5,
    REG_MSR    = 3'd6,
    REG_DIV    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_WO_READ  = 2'd1,
    ERR_RO_WRITE = 2'd2
  } access_err_t;

  // Interrupt identity codes
  typedef enum logic [2:0] {
    IID_MODEM = 3'd0,
    IID_NONE  = 3'd1,
    IID_TX    = 3'd2,
    IID_RX    = 3'd4,
    IID_LINE  = 3'd6
  } iid_t;

  // Line status bits
  localparam logic [7:0] LSR_DR         = 8'h01;
  localparam logic [7:0] LSR_OE         = 8'h02;
  localparam logic [7:0] LSR_HOLD_EMPTY = 8'h20;
  localparam logic [7:0] LSR_LINE_IDLE  = 8'h40;

  // Interrupt enable bit positions
  localparam int unsigned IER_RX    = 0;
  localparam int unsigned IER_TX    = 1;
  localparam int unsigned IER_LINE  = 2;
  localparam int unsigned IER_MODEM = 3;
  localparam int unsigned IER_W     = 4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } req_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
    logic [1:0] access_error;
    logic       rx_ready;
  } rsp_item_t;

  // Architectural state of the register file
  typedef struct packed {
    logic [7:0]        received_data;
    logic              data_ready;
    logic              overrun_sticky;
    logic [IER_W-1:0]  int_enables;
    logic [2:0]        int_ident;
  } uart_state_t;

endpackage

[rtl/core/uart_reg_if.sv]
// ----------------------------------------------------------------------------
// uart_reg_if
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface uart_reg_req_if import uart_reg_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface uart_reg_rsp_if import uart_reg_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[rtl/core/uart_reg_core.sv]
// ----------------------------------------------------------------------------
// uart_reg_core
// Combinational decode of one item: response fields and next register state.
// ----------------------------------------------------------------------------
module uart_reg_core import uart_reg_pkg::*; (
  input  req_item_t   item,
  input  uart_state_t state,
  output uart_state_t state_next,
  output rsp_item_t   rsp
);

  logic [7:0] lsr;
  iid_t       iid;

  assign lsr = LSR_HOLD_EMPTY | LSR_LINE_IDLE
             | (state.overrun_sticky ? LSR_OE : 8'h00)
             | (state.data_ready ? LSR_DR : 8'h00);

  always_comb begin
    state_next       = state;
    rsp.read_data    = 8'h00;
    rsp.tx_valid     = 1'b0;
    rsp.tx_byte      = 8'h00;
    rsp.access_error = ERR_NONE;

    case (mode_t'(item.mode))
      MODE_READ: begin
        case (reg_idx_t'(item.reg_index))
          REG_DATA: begin
            rsp.read_data         = state.received_data;
            state_next.data_ready = 1'b0;
          end
          REG_IDENT: rsp.read_data = {5'd0, state.int_ident};
          REG_LSR:   rsp.read_data = lsr;
          REG_MSR:   rsp.read_data = 8'h00;
          default:   rsp.access_error = ERR_WO_READ;
        endcase
      end
      MODE_WRITE: begin
        case (reg_idx_t'(item.reg_index))
          REG_DATA: begin
            rsp.tx_valid = 1'b1;
            rsp.tx_byte  = item.write_data[7:0];
          end
          REG_ENABLE: state_next.int_enables = item.write_data[IER_W-1:0];
          REG_IDENT, REG_LSR, REG_MSR: rsp.access_error = ERR_RO_WRITE;
          default: ;
        endcase
      end
      MODE_RX: begin
        if (state.data_ready) begin
          state_next.overrun_sticky = 1'b1;
        end
        state_next.data_ready    = 1'b1;
        state_next.received_data = item.rx_byte;
      end
      default: ;
    endcase

    // Prioritize: line error, receive data, transmitter empty
    if (state_next.overrun_sticky && state_next.int_enables[IER_LINE]) begin
      iid = IID_LINE;
    end else if (state_next.data_ready && state_next.int_enables[IER_RX]) begin
      iid = IID_RX;
    end else if (state_next.int_enables[IER_TX]) begin
      iid = IID_TX;
    end else begin
      iid = IID_NONE;
    end

    state_next.int_ident = iid;
    rsp.irq              = (iid != IID_NONE);
    rsp.rx_ready         = ~state_next.data_ready;
  end

endmodule

[rtl/core/uart_register_block.sv]
// ----------------------------------------------------------------------------
// uart_register_block
// Register-mapped UART front end in the style of a 16550.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per handshake: a bus read, a bus write, a byte
//   arriving from the serial line, or an idle item (mode selects which). rsp
//   returns exactly one item for each accepted request: read data, the
//   transmit byte with its strobe, the irq level and rx_ready after the item,
//   and an access error code for reads of write-only or writes of read-only registers.
//   The response is registered: an item accepted at a clock edge appears on
//   rsp right after that edge. Throughput is one item per cycle while rsp is
//   taken; the register state and the interrupt identity are updated at the
//   accepting edge, so the next item sees them at once.
//   The response register is the only buffer. req.ready is high while that
//   register is empty or being drained this cycle, so a stalled receiver
//   holds the pending item and stops further requests with no loss.
//   Reset (rst, synchronous) empties the response register, clears the
//   receive byte, data-ready, overrun and enables, and sets the identity
//   to "no interrupt pending".
// ----------------------------------------------------------------------------
module uart_register_block import uart_reg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  uart_reg_req_if.sink  req,
  uart_reg_rsp_if.source rsp
);

  uart_state_t state;
  uart_state_t state_next;
  rsp_item_t   rsp_comb;
  rsp_item_t   rsp_item;
  logic        rsp_valid;
  logic        accept;

  // Accept while the response slot is free or draining
  assign req.ready = ~rsp_valid | rsp.ready;
  assign accept    = req.valid & req.ready;

  uart_reg_core u_core (
    .item       (req.item),
    .state      (state),
    .state_next (state_next),
    .rsp        (rsp_comb)
  );

  // Register state: advance only on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      state.received_data  <= 8'h00;
      state.data_ready     <= 1'b0;
      state.overrun_sticky <= 1'b0;
      state.int_enables    <= '0;
      state.int_ident      <= IID_NONE;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Response register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_item <= rsp_comb;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.item  = rsp_item;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for uart_register_block. Bus reads, bus writes, line
// bytes and idle items go into the request channel with random gaps. Each
// response is compared field by field against a cycle-free model of the
// register file, while the response side stalls at random.
// ----------------------------------------------------------------------------
module tb;
  import uart_reg_pkg::*;

  // Run limit in clock cycles: room for ~1750 items with their gaps and
  // stalls, taken several times over.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Cycles to wait after the last response before closing the run.
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RANDOM_ITEMS = 1600;

  logic clk = 1'b0;
  logic rst = 1'b1;

  uart_reg_req_if req_ch ();
  uart_reg_rsp_if rsp_ch ();

  uart_register_block dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // Model of the register file: receive holding byte, data-ready, sticky
  // overrun, interrupt enables and the identity left by the last item.
  logic [7:0]       rx_hold;
  logic             rx_pending;
  logic             overrun_seen;
  logic [IER_W-1:0] enables;
  iid_t             ident_now;

  rsp_item_t   expected_rsp[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Idle controls: when clear, the matching side runs back to back.
  bit req_gaps_on   = 1'b1;
  bit rsp_stalls_on = 1'b1;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Work out the response to one item and advance the model state.
  function automatic rsp_item_t uart_predict(req_item_t it);
    rsp_item_t r;
    r = '0;
    case (mode_t'(it.mode))
      MODE_READ: begin
        case (reg_idx_t'(it.reg_index))
          REG_DATA: begin
            r.read_data = rx_hold;
            rx_pending  = 1'b0;
          end
          REG_IDENT: r.read_data = {5'b0, ident_now};
          REG_LSR:   r.read_data = LSR_HOLD_EMPTY | LSR_LINE_IDLE |
                                   (overrun_seen ? LSR_OE : 8'h00) |
                                   (rx_pending ? LSR_DR : 8'h00);
          REG_MSR:   r.read_data = 8'h00;
          default:   r.access_error = ERR_WO_READ;
        endcase
      end
      MODE_WRITE: begin
        case (reg_idx_t'(it.reg_index))
          REG_DATA: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = it.write_data[7:0];
          end
          REG_ENABLE:                 enables = it.write_data[IER_W-1:0];
          REG_IDENT, REG_LSR, REG_MSR: r.access_error = ERR_RO_WRITE;
          default: ;
        endcase
      end
      MODE_RX: begin
        if (rx_pending) overrun_seen = 1'b1;
        rx_pending = 1'b1;
        rx_hold    = it.rx_byte;
      end
      default: ;
    endcase
    // Priority order: line error, receive data, transmitter empty.
    if (overrun_seen && enables[IER_LINE])   ident_now = IID_LINE;
    else if (rx_pending && enables[IER_RX])  ident_now = IID_RX;
    else if (enables[IER_TX])                ident_now = IID_TX;
    else                                     ident_now = IID_NONE;
    r.irq      = (ident_now != IID_NONE);
    r.rx_ready = !rx_pending;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // Scoreboard: check responses against the oldest expectation, then queue
  // the expectation for any request taken at this edge.
  always @(posedge clk) begin : scoreboard
    rsp_item_t want;
    rsp_item_t got;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.item;
        if (expected_rsp.size() == 0) begin
          $error("response with no item outstanding");
          error_count++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("read_data",    32'(want.read_data),    32'(got.read_data));
          check_field("tx_valid",     32'(want.tx_valid),     32'(got.tx_valid));
          check_field("tx_byte",      32'(want.tx_byte),      32'(got.tx_byte));
          check_field("irq",          32'(want.irq),          32'(got.irq));
          check_field("access_error", 32'(want.access_error), 32'(got.access_error));
          check_field("rx_ready",     32'(want.rx_ready),     32'(got.rx_ready));
        end
      end
      if (req_ch.valid && req_ch.ready)
        expected_rsp.push_back(uart_predict(req_ch.item));
    end
  end

  // Response side: hold off for a random number of cycles, then stay ready
  // until one item is taken.
  initial begin : rsp_drain
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    forever begin
      stall = rsp_stalls_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  // Present one item after a random gap and hold it until accepted.
  task automatic send_item(input mode_t mode, input reg_idx_t idx,
                           input logic [31:0] wdata, input logic [7:0] rxb);
    req_item_t   it;
    int unsigned gap;
    it.mode       = mode;
    it.reg_index  = idx;
    it.write_data = wdata;
    it.rx_byte    = rxb;
    gap = req_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.item  <= it;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Identity, status and receive byte straight out of reset.
  task automatic check_reset_values();
    send_item(MODE_READ, REG_IDENT, 32'h0, 8'h00);
    send_item(MODE_READ, REG_LSR,   32'h0, 8'h00);
    send_item(MODE_READ, REG_DATA,  32'h0, 8'h00);
  endtask

  // Reads of write-only registers, writes of read-only ones, and the modem
  // status read, which is legal and always zero.
  task automatic check_access_errors();
    send_item(MODE_READ,  REG_ENABLE, 32'h0,        8'hff);
    send_item(MODE_READ,  REG_LCR,    32'h0,        8'h00);
    send_item(MODE_READ,  REG_MCR,    32'h0,        8'hff);
    send_item(MODE_READ,  REG_DIV,    32'h0,        8'h00);
    send_item(MODE_WRITE, REG_IDENT,  32'hffffffff, 8'h00);
    send_item(MODE_WRITE, REG_LSR,    32'h00000000, 8'h00);
    send_item(MODE_WRITE, REG_MSR,    32'hffffffff, 8'h00);
    send_item(MODE_READ,  REG_MSR,    32'h0,        8'h00);
  endtask

  // Line control, modem control and divisor writes are taken silently.
  task automatic check_ignored_writes();
    send_item(MODE_WRITE, REG_LCR, 32'hffffffff, 8'h00);
    send_item(MODE_WRITE, REG_MCR, 32'hffffffff, 8'h00);
    send_item(MODE_WRITE, REG_DIV, 32'hffffffff, 8'h00);
  endtask

  task automatic check_transmit();
    send_item(MODE_WRITE, REG_DATA, 32'hffffffff, 8'h00);
    send_item(MODE_WRITE, REG_DATA, 32'h00000000, 8'hff);
  endtask

  // Enable write keeps only the low nibble; two bytes without a read in
  // between raise the sticky overrun, which a data read does not clear.
  task automatic check_receive_and_overrun();
    send_item(MODE_WRITE, REG_ENABLE, 32'hfffffff5, 8'h00);
    send_item(MODE_RX,    REG_DATA,   32'h0,        8'hff);
    send_item(MODE_READ,  REG_IDENT,  32'h0,        8'h00);
    send_item(MODE_RX,    REG_DATA,   32'h0,        8'h00);
    send_item(MODE_READ,  REG_IDENT,  32'h0,        8'h00);
    send_item(MODE_READ,  REG_DATA,   32'h0,        8'h00);
    send_item(MODE_READ,  REG_LSR,    32'h0,        8'h00);
    send_item(MODE_IDLE,  REG_DIV,    32'hffffffff, 8'hff);
  endtask

  // Mixed traffic: reads lean toward data, ident and status; writes lean
  // toward data and enables so the interrupt priorities keep moving.
  task automatic run_random_traffic();
    int unsigned sent;
    int unsigned pick;
    mode_t       mode;
    reg_idx_t    idx;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // Change idle behavior every so often, with back-to-back stretches.
      if (sent % 150 == 0) begin
        req_gaps_on   = ($urandom_range(0, 3) != 0);
        rsp_stalls_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35)      mode = MODE_READ;
      else if (pick < 65) mode = MODE_WRITE;
      else if (pick < 93) mode = MODE_RX;
      else                mode = MODE_IDLE;
      pick = $urandom_range(0, 9);
      if (mode == MODE_READ && pick < 6)
        idx = (pick < 3) ? REG_DATA : ((pick < 5) ? REG_LSR : REG_IDENT);
      else if (mode == MODE_WRITE && pick < 6)
        idx = (pick < 3) ? REG_DATA : REG_ENABLE;
      else
        idx = reg_idx_t'($urandom_range(0, 7));
      send_item(mode, idx, $urandom, 8'($urandom_range(0, 255)));
      // Idle items change nothing, so leave them out of the count.
      if (mode != MODE_IDLE) sent++;
    end
  endtask

  initial begin
    rx_hold      = 8'h00;
    rx_pending   = 1'b0;
    overrun_seen = 1'b0;
    enables      = '0;
    ident_now    = IID_NONE;
    req_ch.valid = 1'b0;
    req_ch.item  = '0;

    // Hold reset from the start, release on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_reset_values();
    check_access_errors();
    check_ignored_writes();
    check_transmit();
    check_receive_and_overrun();
    run_random_traffic();

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Drain: wait for every response, then a few more cycles for strays.
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/uart_reg_pkg.sv
rtl/core/uart_reg_if.sv
rtl/core/uart_reg_core.sv
rtl/core/uart_register_block.sv
test/tb.sv
